@@ rtl/gsac_pkg.sv @@
package gsac_pkg;

  localparam int unsigned DutyW  = 12;
  localparam int unsigned TicksW = 16;
  localparam int unsigned PatW   = 4;
  localparam int unsigned GearW  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [31:0] PwmTop = 32'd3199;

  // gear codes (manual request and undefined sensed gear share one code)
  localparam logic [GearW-1:0] GearPark  = 3'd0;
  localparam logic [GearW-1:0] GearRev   = 3'd1;
  localparam logic [GearW-1:0] GearNeu   = 3'd2;
  localparam logic [GearW-1:0] GearDrv   = 3'd3;
  localparam logic [GearW-1:0] GearMan   = 3'd4;
  localparam logic [GearW-1:0] GearUndef = 3'd4;

  localparam logic [1:0] FuncShifter = 2'd0;
  localparam logic [1:0] FuncPos     = 2'd1;
  localparam logic [1:0] FuncTick    = 2'd2;

  localparam logic [7:0] ParkBtnCode  = 8'hD5;
  localparam logic [7:0] LeverRelease = 8'h0F;
  localparam logic [7:0] LeverDown    = 8'h1F;
  localparam logic [7:0] LeverRev     = 8'h2F;
  localparam logic [7:0] LeverUp      = 8'h3F;
  localparam logic [7:0] LeverDrv     = 8'h4F;
  localparam logic [7:0] LeverLatchA  = 8'h5F;
  localparam logic [7:0] LeverLatchB  = 8'h6F;
  localparam logic [7:0] LeverMan     = 8'h7F;

  localparam logic [1:0] ReportNone   = 2'd0;
  localparam logic [1:0] ReportNotRev = 2'd1;
  localparam logic [1:0] ReportRev    = 2'd2;

  localparam logic [1:0] DirOff = 2'd0;
  localparam logic [1:0] DirA   = 2'd1;
  localparam logic [1:0] DirB   = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgSwitchDuty = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgParkDuty   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBrakeDuty  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBrakeTicks = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgParkPat    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRevPat     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgNeuPat     = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgDrvPat     = 3'd7;

  typedef struct packed {
    logic [DutyW-1:0]  switch_duty;
    logic [DutyW-1:0]  park_duty;
    logic [DutyW-1:0]  brake_duty;
    logic [TicksW-1:0] brake_ticks;
    logic [PatW-1:0]   park_pat;
    logic [PatW-1:0]   rev_pat;
    logic [PatW-1:0]   neu_pat;
    logic [PatW-1:0]   drv_pat;
  } cfg_t;

  typedef struct packed {
    logic [GearW-1:0]  request;
    logic              latch;
    logic [GearW-1:0]  sensed;
    logic [TicksW-1:0] brake_cnt;
    logic [1:0]        dir;
    logic [DutyW-1:0]  duty_a;
    logic [DutyW-1:0]  duty_b;
    logic [1:0]        report;
  } state_t;

  typedef struct packed {
    logic [1:0] func;
    logic       pedal;
    logic [7:0] lever;
    logic [7:0] pbtn;
    logic [3:0] bits;
  } item_t;

  function automatic logic [DutyW-1:0] clamp_duty(input logic [DutyW-1:0] d);
    logic [31:0] wide;
    wide = {{(32-DutyW){1'b0}}, d};
    if (wide > PwmTop) begin
      wide = PwmTop;
    end
    return wide[DutyW-1:0];
  endfunction

endpackage

@@ rtl/gear_selector_actuator_controller_unit.sv @@
// Gear selector actuator controller.
// Input channel (in_valid_i/in_ready_o) carries one event per transfer:
// a shifter message, a gear position sensor event or a timer tick.
// Output channel (out_valid_o/out_ready_i) returns exactly one result per
// event: requested and sensed gear, motor bridge lines and duties, the
// reverse report and the braking flag, all as they stand after the event.
// An accepted event passes two register stages, the input register and
// the result register, before it is presented as a result. Throughput:
// one event per cycle while the receiver takes results; the state update
// between the input register and the result register is combinational.
// When the receiver stalls, the result register holds and the input
// register still takes one more event; in_ready_o then drops until the
// result is taken. Reset: gear request park, sensed gear undefined,
// drive off, duties and brake count zero, configuration registers at
// their defaults. Configuration (cfg_we_i/cfg_idx_i/cfg_data_i) is
// written by the user only while idle; the block does not enforce it.
module gear_selector_actuator_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic        pedal_pressed_i,
  input  logic [7:0]  lever_code_i,
  input  logic [7:0]  park_button_i,
  input  logic [3:0]  sensor_bits_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  requested_gear_o,
  output logic [2:0]  sensed_gear_o,
  output logic        drive_fwd_o,
  output logic        drive_rev_o,
  output logic [11:0] duty_fwd_o,
  output logic [11:0] duty_rev_o,
  output logic [1:0]  reverse_report_o,
  output logic        braking_o
);

  gsac_pkg::cfg_t   cfg_q;
  gsac_pkg::state_t state_q, state_d, state_nxt;
  gsac_pkg::item_t  item_q;
  gsac_pkg::state_t res_q;
  logic             item_vld_q, res_vld_q;
  logic             in_xfer, adv;

  assign adv        = item_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.switch_duty <= 12'd1600;
      cfg_q.park_duty   <= 12'd1600;
      cfg_q.brake_duty  <= 12'd800;
      cfg_q.brake_ticks <= 16'd100;
      cfg_q.park_pat    <= 4'd1;
      cfg_q.rev_pat     <= 4'd2;
      cfg_q.neu_pat     <= 4'd4;
      cfg_q.drv_pat     <= 4'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gsac_pkg::CfgSwitchDuty: cfg_q.switch_duty <= cfg_data_i[11:0];
        gsac_pkg::CfgParkDuty:   cfg_q.park_duty   <= cfg_data_i[11:0];
        gsac_pkg::CfgBrakeDuty:  cfg_q.brake_duty  <= cfg_data_i[11:0];
        gsac_pkg::CfgBrakeTicks: cfg_q.brake_ticks <= cfg_data_i;
        gsac_pkg::CfgParkPat:    cfg_q.park_pat    <= cfg_data_i[3:0];
        gsac_pkg::CfgRevPat:     cfg_q.rev_pat     <= cfg_data_i[3:0];
        gsac_pkg::CfgNeuPat:     cfg_q.neu_pat     <= cfg_data_i[3:0];
        gsac_pkg::CfgDrvPat:     cfg_q.drv_pat     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.func  <= func_i;
      item_q.pedal <= pedal_pressed_i;
      item_q.lever <= lever_code_i;
      item_q.pbtn  <= park_button_i;
      item_q.bits  <= sensor_bits_i;
    end
    if (adv) begin
      res_q <= state_nxt;
    end
  end

  gsac_core u_core (
    .cur_i  (state_q),
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .nxt_o  (state_nxt)
  );

  assign state_d = adv ? state_nxt : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.request   <= gsac_pkg::GearPark;
      state_q.latch     <= 1'b0;
      state_q.sensed    <= gsac_pkg::GearUndef;
      state_q.brake_cnt <= '0;
      state_q.dir       <= gsac_pkg::DirOff;
      state_q.duty_a    <= '0;
      state_q.duty_b    <= '0;
      state_q.report    <= gsac_pkg::ReportNone;
      item_vld_q        <= 1'b0;
      res_vld_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        item_vld_q <= 1'b1;
      end else if (adv) begin
        item_vld_q <= 1'b0;
      end
      if (adv) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = res_vld_q;
  assign requested_gear_o = res_q.request;
  assign sensed_gear_o    = res_q.sensed;
  assign drive_fwd_o      = res_q.dir[0];
  assign drive_rev_o      = res_q.dir[1];
  assign duty_fwd_o       = res_q.duty_a;
  assign duty_rev_o       = res_q.duty_b;
  assign reverse_report_o = res_q.report;
  assign braking_o        = (res_q.brake_cnt != '0);

`ifndef SYNTH
  a_dir_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(drive_fwd_o && drive_rev_o))
    else $error("both bridge lines enabled");

  a_duty_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((duty_fwd_o == '0 || drive_fwd_o) &&
                     (duty_rev_o == '0 || drive_rev_o)))
    else $error("duty on a disabled channel");

  a_tick_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && item_q.func == gsac_pkg::FuncTick && state_q.brake_cnt != '0) |=>
    (state_q.brake_cnt == $past(state_q.brake_cnt) - 16'd1))
    else $error("brake countdown did not step");
`endif

endmodule

@@ rtl/gsac_core.sv @@
module gsac_core (
  input  gsac_pkg::state_t cur_i,
  input  gsac_pkg::cfg_t   cfg_i,
  input  gsac_pkg::item_t  item_i,
  output gsac_pkg::state_t nxt_o
);

  gsac_pkg::state_t        s;
  logic [gsac_pkg::GearW-1:0] sensed;

  always_comb begin
    s = cur_i;

    priority if (item_i.bits == cfg_i.park_pat) begin
      sensed = gsac_pkg::GearPark;
    end else if (item_i.bits == cfg_i.rev_pat) begin
      sensed = gsac_pkg::GearRev;
    end else if (item_i.bits == cfg_i.neu_pat) begin
      sensed = gsac_pkg::GearNeu;
    end else if (item_i.bits == cfg_i.drv_pat) begin
      sensed = gsac_pkg::GearDrv;
    end else begin
      sensed = gsac_pkg::GearUndef;
    end

    unique case (item_i.func)
      gsac_pkg::FuncShifter: begin
        if (item_i.pedal) begin
          if (item_i.pbtn == gsac_pkg::ParkBtnCode) begin
            s.request = gsac_pkg::GearPark;
          end
          unique case (item_i.lever)
            gsac_pkg::LeverRelease: s.latch = 1'b0;
            gsac_pkg::LeverDown: begin
              if (!s.latch) begin
                // manual request is kept
                if (s.request == gsac_pkg::GearPark) begin
                  s.request = gsac_pkg::GearNeu;
                end else if (s.request == gsac_pkg::GearRev) begin
                  s.request = gsac_pkg::GearPark;
                end else if (s.request == gsac_pkg::GearNeu) begin
                  s.request = gsac_pkg::GearRev;
                end else if (s.request == gsac_pkg::GearDrv) begin
                  s.request = gsac_pkg::GearNeu;
                end
                s.latch = 1'b1;
              end
            end
            gsac_pkg::LeverRev: s.request = gsac_pkg::GearRev;
            gsac_pkg::LeverUp: begin
              if (!s.latch) begin
                // drive and manual requests are kept
                if (s.request == gsac_pkg::GearPark ||
                    s.request == gsac_pkg::GearRev) begin
                  s.request = gsac_pkg::GearNeu;
                end else if (s.request == gsac_pkg::GearNeu) begin
                  s.request = gsac_pkg::GearDrv;
                end
                s.latch = 1'b1;
              end
            end
            gsac_pkg::LeverDrv: s.request = gsac_pkg::GearDrv;
            gsac_pkg::LeverMan: begin
              s.request = gsac_pkg::GearMan;
              s.latch   = 1'b0;
            end
            gsac_pkg::LeverLatchA, gsac_pkg::LeverLatchB: s.latch = 1'b1;
            default: ;
          endcase
        end
      end
      gsac_pkg::FuncPos: begin
        s.sensed = sensed;
        s.report = (sensed == gsac_pkg::GearRev) ? gsac_pkg::ReportRev
                                                 : gsac_pkg::ReportNotRev;
        if (sensed != gsac_pkg::GearUndef && cur_i.request <= gsac_pkg::GearDrv) begin
          if (sensed == cur_i.request) begin
            // counter-brake on arrival
            s.brake_cnt = cfg_i.brake_ticks;
            if (cur_i.dir == gsac_pkg::DirA) begin
              s.dir    = gsac_pkg::DirB;
              s.duty_a = '0;
              s.duty_b = gsac_pkg::clamp_duty(cfg_i.brake_duty);
            end else if (cur_i.dir == gsac_pkg::DirB) begin
              s.dir    = gsac_pkg::DirA;
              s.duty_a = gsac_pkg::clamp_duty(cfg_i.brake_duty);
              s.duty_b = '0;
            end
          end else if (cur_i.request == gsac_pkg::GearPark) begin
            s.dir    = gsac_pkg::DirB;
            s.duty_a = '0;
            s.duty_b = gsac_pkg::clamp_duty(cfg_i.park_duty);
          end else if (cur_i.request > sensed) begin
            s.dir    = gsac_pkg::DirA;
            s.duty_a = gsac_pkg::clamp_duty(cfg_i.switch_duty);
            s.duty_b = '0;
          end else begin
            s.dir    = gsac_pkg::DirB;
            s.duty_a = '0;
            s.duty_b = gsac_pkg::clamp_duty(cfg_i.switch_duty);
          end
        end
      end
      gsac_pkg::FuncTick: begin
        if (cur_i.brake_cnt != '0) begin
          s.brake_cnt = cur_i.brake_cnt - 1'b1;
        end else begin
          s.dir    = gsac_pkg::DirOff;
          s.duty_a = '0;
          s.duty_b = '0;
        end
      end
      default: ;
    endcase

    nxt_o = s;
  end

endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 4000;
  localparam int PrintLimit = 40;
  localparam int PhaseItems = 210;
  localparam logic [1:0] FuncSpare = 2'd3;

  typedef struct packed {
    logic [gsac_pkg::GearW-1:0] request;
    logic [gsac_pkg::GearW-1:0] sensed;
    logic                       fwd;
    logic                       rev;
    logic [gsac_pkg::DutyW-1:0] duty_fwd;
    logic [gsac_pkg::DutyW-1:0] duty_rev;
    logic [1:0]                 report;
    logic                       braking;
  } gear_view_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic        pedal;
  logic [7:0]  lever;
  logic [7:0]  pbtn;
  logic [3:0]  sensor;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  req_gear;
  logic [2:0]  sensed_gear;
  logic        drive_fwd;
  logic        drive_rev;
  logic [11:0] duty_fwd;
  logic [11:0] duty_rev;
  logic [1:0]  rev_report;
  logic        braking;

  gear_view_t pending_views[$];
  int  error_count;
  int  result_count;
  logic steady;
  int  hold_len;
  int  hold_tag;

  // gear model state
  logic [gsac_pkg::GearW-1:0]  m_request;
  logic                        m_latch;
  logic [gsac_pkg::GearW-1:0]  m_sensed;
  logic [gsac_pkg::TicksW-1:0] m_brake_cnt;
  logic [1:0]                  m_dir;
  logic [gsac_pkg::DutyW-1:0]  m_duty_a;
  logic [gsac_pkg::DutyW-1:0]  m_duty_b;
  logic [1:0]                  m_report;

  // configuration copy
  logic [gsac_pkg::DutyW-1:0]  c_switch;
  logic [gsac_pkg::DutyW-1:0]  c_park;
  logic [gsac_pkg::DutyW-1:0]  c_brake;
  logic [gsac_pkg::TicksW-1:0] c_ticks;
  logic [gsac_pkg::PatW-1:0]   c_pat_p;
  logic [gsac_pkg::PatW-1:0]   c_pat_r;
  logic [gsac_pkg::PatW-1:0]   c_pat_n;
  logic [gsac_pkg::PatW-1:0]   c_pat_d;

  gear_selector_actuator_controller_unit u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .func_i           (func),
    .pedal_pressed_i  (pedal),
    .lever_code_i     (lever),
    .park_button_i    (pbtn),
    .sensor_bits_i    (sensor),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .requested_gear_o (req_gear),
    .sensed_gear_o    (sensed_gear),
    .drive_fwd_o      (drive_fwd),
    .drive_rev_o      (drive_rev),
    .duty_fwd_o       (duty_fwd),
    .duty_rev_o       (duty_rev),
    .reverse_report_o (rev_report),
    .braking_o        (braking)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- gear model

  function automatic void reset_gear_model();
    m_request   = gsac_pkg::GearPark;
    m_latch     = 1'b0;
    m_sensed    = gsac_pkg::GearUndef;
    m_brake_cnt = '0;
    m_dir       = gsac_pkg::DirOff;
    m_duty_a    = '0;
    m_duty_b    = '0;
    m_report    = gsac_pkg::ReportNone;
    c_switch    = 12'd1600;
    c_park      = 12'd1600;
    c_brake     = 12'd800;
    c_ticks     = 16'd100;
    c_pat_p     = 4'd1;
    c_pat_r     = 4'd2;
    c_pat_n     = 4'd4;
    c_pat_d     = 4'd8;
  endfunction

  function automatic logic [gsac_pkg::DutyW-1:0] limit_duty(
      logic [gsac_pkg::DutyW-1:0] d);
    return (d > gsac_pkg::PwmTop[gsac_pkg::DutyW-1:0]) ?
           gsac_pkg::PwmTop[gsac_pkg::DutyW-1:0] : d;
  endfunction

  function automatic void drive_motor(logic [gsac_pkg::DutyW-1:0] d, logic toward_a);
    if (toward_a) begin
      m_dir    = gsac_pkg::DirA;
      m_duty_a = limit_duty(d);
      m_duty_b = '0;
    end else begin
      m_dir    = gsac_pkg::DirB;
      m_duty_a = '0;
      m_duty_b = limit_duty(d);
    end
  endfunction

  function automatic void take_shifter(logic [7:0] lv, logic [7:0] pb);
    if (pb == gsac_pkg::ParkBtnCode) m_request = gsac_pkg::GearPark;
    case (lv)
      gsac_pkg::LeverRelease: m_latch = 1'b0;
      gsac_pkg::LeverDown: begin
        if (!m_latch) begin
          case (m_request)
            gsac_pkg::GearPark: m_request = gsac_pkg::GearNeu;
            gsac_pkg::GearRev:  m_request = gsac_pkg::GearPark;
            gsac_pkg::GearNeu:  m_request = gsac_pkg::GearRev;
            gsac_pkg::GearDrv:  m_request = gsac_pkg::GearNeu;
            default: ;
          endcase
          m_latch = 1'b1;
        end
      end
      gsac_pkg::LeverRev: m_request = gsac_pkg::GearRev;
      gsac_pkg::LeverUp: begin
        if (!m_latch) begin
          if (m_request == gsac_pkg::GearPark || m_request == gsac_pkg::GearRev)
            m_request = gsac_pkg::GearNeu;
          else if (m_request == gsac_pkg::GearNeu)
            m_request = gsac_pkg::GearDrv;
          m_latch = 1'b1;
        end
      end
      gsac_pkg::LeverDrv: m_request = gsac_pkg::GearDrv;
      gsac_pkg::LeverMan: begin
        m_request = gsac_pkg::GearMan;
        m_latch   = 1'b0;
      end
      gsac_pkg::LeverLatchA, gsac_pkg::LeverLatchB: m_latch = 1'b1;
      default: ;
    endcase
  endfunction

  function automatic void take_position(logic [gsac_pkg::PatW-1:0] sb);
    logic [gsac_pkg::GearW-1:0] s;
    if (sb == c_pat_p) s = gsac_pkg::GearPark;
    else if (sb == c_pat_r) s = gsac_pkg::GearRev;
    else if (sb == c_pat_n) s = gsac_pkg::GearNeu;
    else if (sb == c_pat_d) s = gsac_pkg::GearDrv;
    else s = gsac_pkg::GearUndef;
    m_sensed = s;
    m_report = (s == gsac_pkg::GearRev) ? gsac_pkg::ReportRev : gsac_pkg::ReportNotRev;
    if (s != gsac_pkg::GearUndef && m_request <= gsac_pkg::GearDrv) begin
      if (s == m_request) begin
        // counter-brake on arrival
        m_brake_cnt = c_ticks;
        if (m_dir == gsac_pkg::DirA) drive_motor(c_brake, 1'b0);
        else if (m_dir == gsac_pkg::DirB) drive_motor(c_brake, 1'b1);
      end else if (m_request == gsac_pkg::GearPark) begin
        drive_motor(c_park, 1'b0);
      end else if (m_request > s) begin
        drive_motor(c_switch, 1'b1);
      end else begin
        drive_motor(c_switch, 1'b0);
      end
    end
  endfunction

  function automatic gear_view_t advance_gear_model(gsac_pkg::item_t it);
    gear_view_t v;
    case (it.func)
      gsac_pkg::FuncShifter: if (it.pedal) take_shifter(it.lever, it.pbtn);
      gsac_pkg::FuncPos:     take_position(it.bits);
      gsac_pkg::FuncTick: begin
        if (m_brake_cnt != 0) begin
          m_brake_cnt = m_brake_cnt - 1'b1;
        end else begin
          m_dir    = gsac_pkg::DirOff;
          m_duty_a = '0;
          m_duty_b = '0;
        end
      end
      default: ;
    endcase
    v.request  = m_request;
    v.sensed   = m_sensed;
    v.fwd      = m_dir[0];
    v.rev      = m_dir[1];
    v.duty_fwd = m_duty_a;
    v.duty_rev = m_duty_b;
    v.report   = m_report;
    v.braking  = (m_brake_cnt != 0);
    return v;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [7:0] lever_code_at(int idx);
    case (idx)
      0: return gsac_pkg::LeverRelease;
      1: return gsac_pkg::LeverDown;
      2: return gsac_pkg::LeverRev;
      3: return gsac_pkg::LeverUp;
      4: return gsac_pkg::LeverDrv;
      5: return gsac_pkg::LeverLatchA;
      6: return gsac_pkg::LeverLatchB;
      default: return gsac_pkg::LeverMan;
    endcase
  endfunction

  function automatic logic [gsac_pkg::PatW-1:0] pattern_at(int idx);
    case (idx)
      0: return c_pat_p;
      1: return c_pat_r;
      2: return c_pat_n;
      default: return c_pat_d;
    endcase
  endfunction

  function automatic gsac_pkg::item_t make_event(logic [1:0] f, logic p, logic [7:0] lv,
                                                 logic [7:0] pb, logic [3:0] sb);
    gsac_pkg::item_t it;
    it.func  = f;
    it.pedal = p;
    it.lever = lv;
    it.pbtn  = pb;
    it.bits  = sb;
    return it;
  endfunction

  function automatic gsac_pkg::item_t random_event();
    gsac_pkg::item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 36) it.func = gsac_pkg::FuncShifter;
    else if (r < 70) it.func = gsac_pkg::FuncPos;
    else if (r < 96) it.func = gsac_pkg::FuncTick;
    else it.func = FuncSpare;
    it.pedal = ($urandom_range(0, 99) < 85);
    if ($urandom_range(0, 99) < 80) it.lever = lever_code_at($urandom_range(0, 7));
    else it.lever = 8'($urandom);
    if ($urandom_range(0, 99) < 15) it.pbtn = gsac_pkg::ParkBtnCode;
    else it.pbtn = 8'($urandom);
    if ($urandom_range(0, 99) < 75) it.bits = pattern_at($urandom_range(0, 3));
    else it.bits = 4'($urandom);
    return it;
  endfunction

  task automatic send_event(gsac_pkg::item_t it, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    func     = it.func;
    pedal    = it.pedal;
    lever    = it.lever;
    pbtn     = it.pbtn;
    sensor   = it.bits;
    do @(posedge clk); while (!in_ready);
    pending_views.push_back(advance_gear_model(it));
  endtask

  task automatic shift(logic p, logic [7:0] lv, logic [7:0] pb);
    send_event(make_event(gsac_pkg::FuncShifter, p, lv, pb, 4'($urandom)), pick_gap());
  endtask

  task automatic sense(logic [3:0] sb);
    send_event(make_event(gsac_pkg::FuncPos, 1'($urandom), 8'($urandom), 8'($urandom), sb),
               pick_gap());
  endtask

  task automatic tick_once();
    send_event(make_event(gsac_pkg::FuncTick, 1'($urandom), 8'($urandom), 8'($urandom),
                          4'($urandom)),
               pick_gap());
  endtask

  // drop valid and wait until every transfer has produced its result
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [gsac_pkg::CfgIdxW-1:0] idx,
                           logic [gsac_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we   = 1'b0;
    case (idx)
      gsac_pkg::CfgSwitchDuty: c_switch = data[gsac_pkg::DutyW-1:0];
      gsac_pkg::CfgParkDuty:   c_park   = data[gsac_pkg::DutyW-1:0];
      gsac_pkg::CfgBrakeDuty:  c_brake  = data[gsac_pkg::DutyW-1:0];
      gsac_pkg::CfgBrakeTicks: c_ticks  = data[gsac_pkg::TicksW-1:0];
      gsac_pkg::CfgParkPat:    c_pat_p  = data[gsac_pkg::PatW-1:0];
      gsac_pkg::CfgRevPat:     c_pat_r  = data[gsac_pkg::PatW-1:0];
      gsac_pkg::CfgNeuPat:     c_pat_n  = data[gsac_pkg::PatW-1:0];
      gsac_pkg::CfgDrvPat:     c_pat_d  = data[gsac_pkg::PatW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_patterns(logic [3:0] p, logic [3:0] r, logic [3:0] n,
                                logic [3:0] d);
    write_reg(gsac_pkg::CfgParkPat, {12'd0, p});
    write_reg(gsac_pkg::CfgRevPat,  {12'd0, r});
    write_reg(gsac_pkg::CfgNeuPat,  {12'd0, n});
    write_reg(gsac_pkg::CfgDrvPat,  {12'd0, d});
  endtask

  task automatic apply_setting(int kind);
    logic [3:0] base;
    settle();
    base = 4'($urandom);
    case (kind)
      0: begin
        write_reg(gsac_pkg::CfgSwitchDuty, 16'd4095);
        write_reg(gsac_pkg::CfgParkDuty,   16'd3199);
        write_reg(gsac_pkg::CfgBrakeDuty,  16'd4095);
        write_reg(gsac_pkg::CfgBrakeTicks, 16'hFFFF);
        write_patterns(4'hF, 4'h0, 4'hF, 4'h0);
      end
      1: begin
        write_reg(gsac_pkg::CfgSwitchDuty, 16'd0);
        write_reg(gsac_pkg::CfgParkDuty,   16'd0);
        write_reg(gsac_pkg::CfgBrakeDuty,  16'd0);
        write_reg(gsac_pkg::CfgBrakeTicks, 16'd0);
        write_patterns(4'h0, 4'h1, 4'hE, 4'hF);
      end
      2: begin
        write_reg(gsac_pkg::CfgSwitchDuty, 16'($urandom_range(0, 4095)));
        write_reg(gsac_pkg::CfgParkDuty,   16'($urandom_range(0, 4095)));
        write_reg(gsac_pkg::CfgBrakeDuty,  16'($urandom_range(0, 4095)));
        write_reg(gsac_pkg::CfgBrakeTicks, 16'($urandom_range(0, 5)));
        write_patterns(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
      end
      default: begin
        write_reg(gsac_pkg::CfgSwitchDuty, 16'($urandom_range(1, 3199)));
        write_reg(gsac_pkg::CfgParkDuty,   16'($urandom_range(1, 3199)));
        write_reg(gsac_pkg::CfgBrakeDuty,  16'($urandom_range(1, 3199)));
        write_reg(gsac_pkg::CfgBrakeTicks, 16'($urandom_range(1, 12)));
        write_patterns(base, base ^ 4'h1, base ^ 4'h2, base ^ 4'h3);
      end
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_ignored_events();
    shift(1'b0, gsac_pkg::LeverRev, gsac_pkg::ParkBtnCode);
    send_event(make_event(FuncSpare, 1'b1, gsac_pkg::LeverDrv, gsac_pkg::ParkBtnCode, 4'h8),
               pick_gap());
    tick_once();
  endtask

  task automatic test_lever_moves();
    shift(1'b1, gsac_pkg::LeverUp, 8'h00);
    shift(1'b1, gsac_pkg::LeverUp, 8'h00);
    shift(1'b1, gsac_pkg::LeverRelease, 8'h00);
    shift(1'b1, gsac_pkg::LeverDown, 8'h00);
    shift(1'b1, gsac_pkg::LeverRelease, 8'hFF);
    shift(1'b1, gsac_pkg::LeverLatchB, 8'h00);
    shift(1'b1, gsac_pkg::LeverDown, 8'h00);
    shift(1'b1, gsac_pkg::LeverDrv, 8'h00);
    shift(1'b1, gsac_pkg::LeverMan, 8'h00);
    shift(1'b1, gsac_pkg::LeverLatchA, 8'h00);
    shift(1'b1, 8'hA3, gsac_pkg::ParkBtnCode);
    shift(1'b1, gsac_pkg::LeverRev, gsac_pkg::ParkBtnCode);
  endtask

  task automatic test_position_drive();
    sense(4'h8);
    sense(4'h2);
    tick_once();
    sense(4'h0);
    shift(1'b1, 8'h00, gsac_pkg::ParkBtnCode);
    sense(4'h4);
    sense(4'h1);
    sense(4'hF);
    shift(1'b1, gsac_pkg::LeverDrv, 8'h00);
    sense(4'h4);
    shift(1'b1, gsac_pkg::LeverMan, 8'h00);
    sense(4'h8);
  endtask

  task automatic test_setting_phases();
    int phase;
    int n;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: ;
        1: apply_setting(3);
        2: apply_setting(0);
        3: apply_setting(2);
        4: apply_setting(1);
        6: apply_setting(3);
        default: apply_setting(2);
      endcase
      steady = (phase == 2);
      for (n = 0; n < PhaseItems; n++) send_event(random_event(), pick_gap());
      steady = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    int n;
    steady   = 1'b1;
    hold_len = 300;
    hold_tag = hold_tag + 1;
    for (n = 0; n < 40; n++) send_event(random_event(), 0);
    steady   = 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_error(string msg);
    if (error_count < PrintLimit) $display("ERROR result %0d: %s", result_count, msg);
    error_count = error_count + 1;
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    int seen_tag;
    stall_left = 0;
    hold_left  = 0;
    seen_tag   = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_tag != seen_tag) begin
        seen_tag  = hold_tag;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left = hold_left - 1;
      end else if (steady) begin
        out_ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ready  = 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ready  = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : result_check
    gear_view_t got;
    gear_view_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.request  = req_gear;
        got.sensed   = sensed_gear;
        got.fwd      = drive_fwd;
        got.rev      = drive_rev;
        got.duty_fwd = duty_fwd;
        got.duty_rev = duty_rev;
        got.report   = rev_report;
        got.braking  = braking;
        if (pending_views.size() == 0) begin
          report_error("transfer with no result pending");
        end else begin
          want = pending_views.pop_front();
          if (got.request !== want.request)
            report_error($sformatf("requested_gear %0d, want %0d", got.request, want.request));
          if (got.sensed !== want.sensed)
            report_error($sformatf("sensed_gear %0d, want %0d", got.sensed, want.sensed));
          if (got.fwd !== want.fwd)
            report_error($sformatf("drive_fwd %0b, want %0b", got.fwd, want.fwd));
          if (got.rev !== want.rev)
            report_error($sformatf("drive_rev %0b, want %0b", got.rev, want.rev));
          if (got.duty_fwd !== want.duty_fwd)
            report_error($sformatf("duty_fwd %0d, want %0d", got.duty_fwd, want.duty_fwd));
          if (got.duty_rev !== want.duty_rev)
            report_error($sformatf("duty_rev %0d, want %0d", got.duty_rev, want.duty_rev));
          if (got.report !== want.report)
            report_error($sformatf("reverse_report %0d, want %0d", got.report, want.report));
          if (got.braking !== want.braking)
            report_error($sformatf("braking %0b, want %0b", got.braking, want.braking));
        end
        result_count = result_count + 1;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = gsac_pkg::CfgSwitchDuty;
    cfg_data     = '0;
    in_valid     = 1'b0;
    func         = gsac_pkg::FuncShifter;
    pedal        = 1'b0;
    lever        = '0;
    pbtn         = '0;
    sensor       = '0;
    steady       = 1'b0;
    hold_len     = 0;
    hold_tag     = 0;
    error_count  = 0;
    result_count = 0;
    reset_gear_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_ignored_events();
    test_lever_moves();
    test_position_drive();
    test_setting_phases();
    test_backpressure();

    settle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
